>>> rtl/sos_pkg.sv
package sos_pkg;

    // Field widths fixed by the request and response formats.
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned POS_W    = 9;

    // Operation carried by a request.
    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_SEARCH = 1'b1
    } t_op;

    // Response status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_FOUND     = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_EMPTY     = 3'd5
    } t_status;

    // Classified request passed from the front end to the engine.
    typedef struct packed {
        t_op                        op;
        logic                       odd;
        logic signed [VALUE_W-1:0]  value;
    } t_cmd;

endpackage

>>> rtl/sos_if.sv
// Request channel: operation kind and value.
interface sos_req_if;
    logic                                valid;
    logic                                ready;
    logic                                kind;
    logic signed [sos_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

// Response channel: status, position, set used and its entry count.
interface sos_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [sos_pkg::STATUS_W-1:0]  status;
    logic [sos_pkg::POS_W-1:0]     position;
    logic                          odd_set;
    logic [sos_pkg::POS_W-1:0]     set_count;

    modport source (output valid, output status, output position, output odd_set,
                    output set_count, input ready);
    modport sink   (input valid, input status, input position, input odd_set,
                    input set_count, output ready);
endinterface

>>> rtl/sos_front.sv
module sos_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    sos_req_if.sink            i_req,
    output logic               o_cmd_valid,
    input  logic               i_cmd_ready,
    output sos_pkg::t_cmd      o_cmd
);

    localparam int unsigned QUEUE_DEPTH = 2;

    sos_pkg::t_cmd  r_q [QUEUE_DEPTH];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_fill;

    sos_pkg::t_cmd  w_cmd;
    logic           w_push;
    logic           w_pop;

    // Classify the incoming request by operation and parity.
    always_comb begin
        w_cmd.op    = sos_pkg::t_op'(i_req.kind);
        w_cmd.odd   = i_req.value[0];
        w_cmd.value = i_req.value;
    end

    assign i_req.ready = (r_fill != 2'(QUEUE_DEPTH));
    assign w_push      = i_req.valid && i_req.ready;
    assign o_cmd_valid = (r_fill != 2'd0);
    assign w_pop       = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_q[r_rd_ptr];

    // Queue storage; payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_cmd;
        end
    end

    // Queue pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({w_push, w_pop})
                2'b10:   r_fill <= r_fill + 2'd1;
                2'b01:   r_fill <= r_fill - 2'd1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

>>> rtl/sos_engine.sv
module sos_engine #(
    parameter int unsigned CAPACITY = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    output logic               o_cmd_ready,
    input  sos_pkg::t_cmd      i_cmd,
    sos_rsp_if.source          o_rsp
);

    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned MD = 2 ** (AW + 1);
    localparam int unsigned XW = (CW > sos_pkg::POS_W) ? CW : sos_pkg::POS_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROBE,
        S_CMP,
        S_SH_RD,
        S_SH_WR,
        S_INS_WR,
        S_DONE
    } t_state;

    // Both sets share one memory; the top address bit selects the odd set.
    logic signed [sos_pkg::VALUE_W-1:0] r_mem [MD];
    logic signed [sos_pkg::VALUE_W-1:0] r_rd_data;

    t_state                r_state,  n_state;
    sos_pkg::t_cmd         r_cmd,    n_cmd;
    logic [CW-1:0]         r_cnt [2];
    logic [CW-1:0]         n_cnt [2];
    logic [CW-1:0]         r_n,      n_n;
    logic [CW-1:0]         r_lo,     n_lo;
    logic [CW-1:0]         r_hi,     n_hi;
    logic [CW-1:0]         r_mid,    n_mid;
    logic [CW-1:0]         r_k,      n_k;
    logic                  r_hit,    n_hit;
    sos_pkg::t_status      r_status, n_status;

    logic                            r_o_valid,  n_o_valid;
    sos_pkg::t_status                r_o_status, n_o_status;
    logic [sos_pkg::POS_W-1:0]       r_o_pos,    n_o_pos;
    logic                            r_o_odd,    n_o_odd;
    logic [sos_pkg::POS_W-1:0]       r_o_count,  n_o_count;

    logic [CW:0]                     w_sum;
    logic [CW-1:0]                   w_mid;
    logic [CW-1:0]                   w_k_dec;
    logic [AW:0]                     w_ra;
    logic [AW:0]                     w_wa;
    logic                            w_we;
    logic signed [sos_pkg::VALUE_W-1:0] w_wd;
    logic                            w_out_free;
    logic [XW-1:0]                   w_pos_x;
    logic [XW-1:0]                   w_cnt_x;

    assign w_sum      = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid      = w_sum[CW:1];
    assign w_k_dec    = r_k - CW'(1);
    assign w_out_free = !r_o_valid || o_rsp.ready;
    assign w_pos_x    = XW'(r_lo + CW'(1));
    assign w_cnt_x    = XW'(r_n);
    assign o_cmd_ready = (r_state == S_IDLE);

    assign o_rsp.valid     = r_o_valid;
    assign o_rsp.status    = r_o_status;
    assign o_rsp.position  = r_o_pos;
    assign o_rsp.odd_set   = r_o_odd;
    assign o_rsp.set_count = r_o_count;

    // Set memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_rd_data <= r_mem[w_ra];
    end

    // Sequencer: binary search for lower bound; inserts shift, then write.
    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_cnt      = r_cnt;
        n_n        = r_n;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_mid      = r_mid;
        n_k        = r_k;
        n_hit      = r_hit;
        n_status   = r_status;
        n_o_valid  = r_o_valid && !o_rsp.ready;
        n_o_status = r_o_status;
        n_o_pos    = r_o_pos;
        n_o_odd    = r_o_odd;
        n_o_count  = r_o_count;
        w_ra       = '0;
        w_wa       = '0;
        w_we       = 1'b0;
        w_wd       = r_cmd.value;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_cmd   = i_cmd;
                    n_n     = r_cnt[i_cmd.odd];
                    n_lo    = '0;
                    n_hi    = r_cnt[i_cmd.odd];
                    n_hit   = 1'b0;
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                if (r_lo < r_hi) begin
                    w_ra    = {r_cmd.odd, w_mid[AW-1:0]};
                    n_mid   = w_mid;
                    n_state = S_CMP;
                end else if (r_cmd.op == sos_pkg::OP_SEARCH) begin
                    if (r_n == '0) begin
                        n_status = sos_pkg::ST_EMPTY;
                    end else if (r_hit) begin
                        n_status = sos_pkg::ST_FOUND;
                    end else begin
                        n_status = sos_pkg::ST_NOT_FOUND;
                    end
                    n_state = S_DONE;
                end else if (r_hit) begin
                    n_status = sos_pkg::ST_DUPLICATE;
                    n_state  = S_DONE;
                end else if (r_n >= CW'(CAPACITY)) begin
                    n_status = sos_pkg::ST_FULL;
                    n_state  = S_DONE;
                end else begin
                    n_k     = r_n;
                    n_state = S_SH_RD;
                end
            end
            S_CMP: begin
                if (r_rd_data < r_cmd.value) begin
                    n_lo = r_mid + CW'(1);
                end else begin
                    n_hi = r_mid;
                end
                if (r_rd_data == r_cmd.value) begin
                    n_hit = 1'b1;
                end
                n_state = S_PROBE;
            end
            S_SH_RD: begin
                if (r_k > r_lo) begin
                    w_ra    = {r_cmd.odd, w_k_dec[AW-1:0]};
                    n_state = S_SH_WR;
                end else begin
                    n_state = S_INS_WR;
                end
            end
            S_SH_WR: begin
                w_we    = 1'b1;
                w_wa    = {r_cmd.odd, r_k[AW-1:0]};
                w_wd    = r_rd_data;
                n_k     = w_k_dec;
                n_state = S_SH_RD;
            end
            S_INS_WR: begin
                w_we               = 1'b1;
                w_wa               = {r_cmd.odd, r_lo[AW-1:0]};
                w_wd               = r_cmd.value;
                n_cnt[r_cmd.odd]   = r_n + CW'(1);
                n_n                = r_n + CW'(1);
                n_status           = sos_pkg::ST_INSERTED;
                n_state            = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_status;
                    n_o_pos    = (r_status == sos_pkg::ST_FOUND) ?
                                 w_pos_x[sos_pkg::POS_W-1:0] : '0;
                    n_o_odd    = r_cmd.odd;
                    n_o_count  = w_cnt_x[sos_pkg::POS_W-1:0];
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt[0]  <= '0;
            r_cnt[1]  <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_o_valid <= n_o_valid;
        end
        r_cmd      <= n_cmd;
        r_n        <= n_n;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_mid      <= n_mid;
        r_k        <= n_k;
        r_hit      <= n_hit;
        r_status   <= n_status;
        r_o_status <= n_o_status;
        r_o_pos    <= n_o_pos;
        r_o_odd    <= n_o_odd;
        r_o_count  <= n_o_count;
    end

    // Neither set ever holds more entries than its capacity.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt[0] <= CW'(CAPACITY)) && (r_cnt[1] <= CW'(CAPACITY)))
        else $error("set count above capacity");

    // The search window never inverts while probing.
    a_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE || r_state == S_CMP) |-> (r_lo <= r_hi))
        else $error("search window inverted");

    // Only a found result carries a nonzero position.
    a_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_status != sos_pkg::ST_FOUND) |-> (r_o_pos == '0))
        else $error("position set on a result other than found");

    // A shift never moves past the insertion point.
    a_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SH_WR) |-> (r_k > r_lo))
        else $error("shift below insertion point");

endmodule

>>> rtl/sorted_odd_even_set.sv
// Two ascending sets of signed 32-bit values, one for even and one for odd
// values, held in a single one-write, one-read memory. Each request either
// inserts its value into the set its parity selects or searches for it there,
// and produces exactly one response. A two-entry request queue sits in front
// of the engine, and the response register lets the next request be taken
// while a response waits. A search is a binary search over the entries of the
// set used, in which every probe is one memory read followed by one compare.
// An insert runs the same search, then moves each entry above the insertion
// point up one place, one read and one write per entry, and ends with a final
// write. Entries sit in memory that is never cleared: only entries below a
// set's count are ever read.
module sorted_odd_even_set #(
    parameter int unsigned CAPACITY = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sos_req_if.sink     i_req,
    sos_rsp_if.source   o_rsp
);

    logic           w_cmd_valid;
    logic           w_cmd_ready;
    sos_pkg::t_cmd  w_cmd;

    // Request intake and classification.
    sos_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_ready (w_cmd_ready),
        .o_cmd       (w_cmd)
    );

    // Set storage, search and insertion.
    sos_engine #(
        .CAPACITY (CAPACITY)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_ready (w_cmd_ready),
        .i_cmd       (w_cmd),
        .o_rsp       (o_rsp)
    );

endmodule
